// ----- design/tsc_pkg.sv -----
// Shared types and constants for the thresholded spot centroid.
// No dependencies.
`default_nettype none

package tsc_pkg;

    localparam int PIX_W      = 16;   // raw pixel
    localparam int POS_W      = 5;    // column / row tag
    localparam int WIN_W      = 6;    // window size field
    localparam int SUB_W      = 12;   // subaperture index
    localparam int THR_W      = 20;   // threshold in 1/16 counts
    localparam int WGT_W      = 27;   // kept pixel sum
    localparam int MOM_W      = 32;   // x / y moments
    localparam int CENT_W     = 13;   // centroid, Q5.8
    localparam int FRAC_BITS  = 8;
    localparam int MAX_WINDOW = 32;
    localparam int DATA_W     = 32;   // config bus data

    localparam logic [CENT_W-1:0] CENT_MAX = {CENT_W{1'b1}};
    localparam logic [WGT_W-1:0]  WGT_MAX  = {WGT_W{1'b1}};
    localparam logic [MOM_W-1:0]  MOM_MAX  = {MOM_W{1'b1}};

    // Register index codes
    localparam logic REG_THRESHOLD = 1'b0;

    // One finished window, handed from front to back
    typedef struct packed {
        logic [SUB_W-1:0] subap;
        logic [PIX_W-1:0] peak;
        logic [MOM_W-1:0] x_moment;
        logic [MOM_W-1:0] y_moment;
        logic [WGT_W-1:0] weight;
        logic [WIN_W-1:0] win_width;
        logic [WIN_W-1:0] win_height;
        logic             spot;
    } job_t;

endpackage

`default_nettype wire

// ----- design/tsc_front.sv -----
// Front end: per-pixel peak tracking and thresholded moment accumulation.
// Depends on tsc_pkg.
`default_nettype none

module tsc_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic [tsc_pkg::PIX_W-1:0] pixel_value,
    input  wire logic [tsc_pkg::POS_W-1:0] col,
    input  wire logic [tsc_pkg::POS_W-1:0] row,
    input  wire logic [tsc_pkg::WIN_W-1:0] win_width,
    input  wire logic [tsc_pkg::WIN_W-1:0] win_height,
    input  wire logic [tsc_pkg::SUB_W-1:0] subap_index,
    input  wire logic                      last_pixel,
    input  wire logic [tsc_pkg::THR_W-1:0] threshold,
    output logic                           push,
    output tsc_pkg::job_t                  job
);

    logic [tsc_pkg::PIX_W-1:0] peak_reg, peak_next;
    logic [tsc_pkg::WGT_W-1:0] weight_reg, weight_next;
    logic [tsc_pkg::MOM_W-1:0] xm_reg, xm_next;
    logic [tsc_pkg::MOM_W-1:0] ym_reg, ym_next;

    logic                                keep;
    logic [tsc_pkg::WGT_W:0]             wsum;
    logic [tsc_pkg::PIX_W+tsc_pkg::POS_W-1:0] xprod, yprod;
    logic [tsc_pkg::MOM_W:0]             xsum, ysum;

    always_comb begin
        peak_next = (pixel_value > peak_reg) ? pixel_value : peak_reg;
        keep  = {pixel_value, 4'b0} >= threshold;
        xprod = pixel_value * col;
        yprod = pixel_value * row;
        wsum  = {1'b0, weight_reg} + (tsc_pkg::WGT_W+1)'(pixel_value);
        xsum  = {1'b0, xm_reg} + (tsc_pkg::MOM_W+1)'(xprod);
        ysum  = {1'b0, ym_reg} + (tsc_pkg::MOM_W+1)'(yprod);
        weight_next = weight_reg;
        xm_next     = xm_reg;
        ym_next     = ym_reg;
        if (keep) begin
            // saturating accumulate
            weight_next = wsum[tsc_pkg::WGT_W] ? tsc_pkg::WGT_MAX : wsum[tsc_pkg::WGT_W-1:0];
            xm_next     = xsum[tsc_pkg::MOM_W] ? tsc_pkg::MOM_MAX : xsum[tsc_pkg::MOM_W-1:0];
            ym_next     = ysum[tsc_pkg::MOM_W] ? tsc_pkg::MOM_MAX : ysum[tsc_pkg::MOM_W-1:0];
        end
    end

    assign push            = accept && last_pixel;
    assign job.subap       = subap_index;
    assign job.peak        = peak_next;
    assign job.x_moment    = xm_next;
    assign job.y_moment    = ym_next;
    assign job.weight      = weight_next;
    assign job.win_width   = win_width;
    assign job.win_height  = win_height;
    assign job.spot        = ({peak_next, 4'b0} > threshold) && (weight_next != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg   <= '0;
            weight_reg <= '0;
            xm_reg     <= '0;
            ym_reg     <= '0;
        end else if (accept) begin
            if (last_pixel) begin
                peak_reg   <= '0;
                weight_reg <= '0;
                xm_reg     <= '0;
                ym_reg     <= '0;
            end else begin
                peak_reg   <= peak_next;
                weight_reg <= weight_next;
                xm_reg     <= xm_next;
                ym_reg     <= ym_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/tsc_queue.sv -----
// Short job queue between front and back ends.
// Depends on tsc_pkg.
`default_nettype none

module tsc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tsc_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output tsc_pkg::job_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsc_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && not_empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/tsc_div.sv -----
// Restoring divider: (moment << FRAC_BITS) / weight, one quotient bit per cycle,
// saturating at the centroid range. Depends on tsc_pkg.
`default_nettype none

module tsc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [tsc_pkg::MOM_W-1:0]  dividend,
    input  wire logic [tsc_pkg::WGT_W-1:0]  divisor,
    output logic                            done,
    output logic [tsc_pkg::CENT_W-1:0]      quotient
);

    localparam int SH    = tsc_pkg::CENT_W - tsc_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(tsc_pkg::CENT_W + 1);

    logic                        busy_reg, done_reg, ovf_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [tsc_pkg::WGT_W-1:0]   rem_reg, den_reg;
    logic [tsc_pkg::CENT_W-1:0]  bits_reg, quo_reg;

    logic [tsc_pkg::WGT_W:0]     trial, diff;
    logic                        ge;

    always_comb begin
        trial = {rem_reg, bits_reg[tsc_pkg::CENT_W-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? tsc_pkg::CENT_MAX : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                // quotient needs more than CENT_W bits: saturate
                ovf_reg  <= dividend >= {divisor, {SH{1'b0}}};
                rem_reg  <= dividend[tsc_pkg::MOM_W-1:SH];
                den_reg  <= divisor;
                bits_reg <= {dividend[SH-1:0], {tsc_pkg::FRAC_BITS{1'b0}}};
                quo_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[tsc_pkg::WGT_W-1:0] : trial[tsc_pkg::WGT_W-1:0];
                bits_reg <= {bits_reg[tsc_pkg::CENT_W-2:0], 1'b0};
                quo_reg  <= {quo_reg[tsc_pkg::CENT_W-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(tsc_pkg::CENT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/tsc_back.sv -----
// Back end: takes a finished window off the queue, divides, picks the
// fallback centre when no spot, and holds the result word. Depends on tsc_pkg, tsc_div.
`default_nettype none

module tsc_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        job_avail,
    input  wire tsc_pkg::job_t               job,
    output logic                             pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tsc_pkg::SUB_W-1:0]        res_subap,
    output logic [tsc_pkg::PIX_W-1:0]        res_peak,
    output logic [tsc_pkg::CENT_W-1:0]       res_cx,
    output logic [tsc_pkg::CENT_W-1:0]       res_cy,
    output logic                             res_spot
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    tsc_pkg::job_t                  job_reg;
    logic                           valid_reg;
    logic [tsc_pkg::SUB_W-1:0]      subap_reg;
    logic [tsc_pkg::PIX_W-1:0]      peak_reg;
    logic [tsc_pkg::CENT_W-1:0]     cx_reg, cy_reg;
    logic                           spot_reg;

    logic                           x_done, y_done;
    logic [tsc_pkg::CENT_W-1:0]     x_quo, y_quo;
    logic                           out_free;
    logic [tsc_pkg::CENT_W-1:0]     cx_ctr, cy_ctr;

    function automatic logic [tsc_pkg::CENT_W-1:0] win_centre(
        input logic [tsc_pkg::WIN_W-1:0] size
    );
        logic [tsc_pkg::WIN_W-1:0] sz;
        logic [tsc_pkg::WIN_W-1:0] szm1;
        begin
            sz = size;
            if (sz == '0) sz = tsc_pkg::WIN_W'(1);
            if (sz > tsc_pkg::WIN_W'(tsc_pkg::MAX_WINDOW)) sz = tsc_pkg::WIN_W'(tsc_pkg::MAX_WINDOW);
            szm1 = sz - 1'b1;
            // (size-1)/2 in Q.FRAC_BITS
            win_centre = tsc_pkg::CENT_W'({szm1, {(tsc_pkg::FRAC_BITS-1){1'b0}}});
        end
    endfunction

    assign pop      = (state_reg == ST_IDLE) && job_avail;
    assign out_free = !valid_reg || m_ready;
    assign cx_ctr   = win_centre(job_reg.win_width);
    assign cy_ctr   = win_centre(job_reg.win_height);

    tsc_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pop),
        .dividend (job.x_moment),
        .divisor  (job.weight),
        .done     (x_done),
        .quotient (x_quo)
    );

    tsc_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pop),
        .dividend (job.y_moment),
        .divisor  (job.weight),
        .done     (y_done),
        .quotient (y_quo)
    );

    assign m_valid   = valid_reg;
    assign res_subap = subap_reg;
    assign res_peak  = peak_reg;
    assign res_cx    = cx_reg;
    assign res_cy    = cy_reg;
    assign res_spot  = spot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            // a new word replaces the one taken at this edge
            if (state_reg == ST_DONE && out_free) begin
                valid_reg <= 1'b1;
            end else if (valid_reg && m_ready) begin
                valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_avail) begin
                        job_reg   <= job;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // both dividers run the same fixed number of steps
                    if (x_done && y_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        subap_reg <= job_reg.subap;
                        peak_reg  <= job_reg.peak;
                        spot_reg  <= job_reg.spot;
                        cx_reg    <= job_reg.spot ? x_quo : cx_ctr;
                        cy_reg    <= job_reg.spot ? y_quo : cy_ctr;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/thresholded_spot_centroid.sv -----
// Thresholded centre-of-gravity spot centroid, top level.
// Path from last pixel to result word: queue, 13-step divide, output register.
// Throughput: one pixel per cycle while the job queue is not full; the back end takes one
// window at a time, paced by the bit-serial divider; the job queue absorbs bursts of short windows.
// Reset (aresetn, synchronous): accumulators, queue, threshold and result valid cleared.
// Depends on tsc_pkg, tsc_front, tsc_queue, tsc_back.
`default_nettype none

module thresholded_spot_centroid #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] pixel_value, [20:16] col, [25:21] row, [31:26] win_width,
    // [37:32] win_height, [49:38] subap_index, [55:50] zero
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tlast,     // last_pixel

    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [11:0] result_subap, [27:12] peak_out, [40:28] centroid_x,
    // [53:41] centroid_y, [55:54] zero
    output logic [55:0]      m_tdata,
    output logic [0:0]       m_tuser,     // spot_valid

    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Threshold register, 1/16 counts
    logic [tsc_pkg::THR_W-1:0] thr_reg;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == tsc_pkg::REG_THRESHOLD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            thr_reg <= pwdata[tsc_pkg::THR_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(tsc_pkg::DATA_W-tsc_pkg::THR_W){1'b0}}, thr_reg} : '0;

    // Front end: accumulate. A pixel is taken whenever the queue has room,
    // so a last pixel can always be pushed.
    logic          q_full, q_avail, push, pop, s_accept;
    tsc_pkg::job_t front_job, head_job;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    tsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .pixel_value (s_tdata[15:0]),
        .col         (s_tdata[20:16]),
        .row         (s_tdata[25:21]),
        .win_width   (s_tdata[31:26]),
        .win_height  (s_tdata[37:32]),
        .subap_index (s_tdata[49:38]),
        .last_pixel  (s_tlast),
        .threshold   (thr_reg),
        .push        (push),
        .job         (front_job)
    );

    // Window jobs waiting for the divider
    tsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_avail),
        .head      (head_job)
    );

    // Back end: divide and present the result word
    logic [tsc_pkg::SUB_W-1:0]  res_subap;
    logic [tsc_pkg::PIX_W-1:0]  res_peak;
    logic [tsc_pkg::CENT_W-1:0] res_cx, res_cy;
    logic                       res_spot;

    tsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (q_avail),
        .job       (head_job),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .res_subap (res_subap),
        .res_peak  (res_peak),
        .res_cx    (res_cx),
        .res_cy    (res_cy),
        .res_spot  (res_spot)
    );

    assign m_tdata  = {2'b00, res_cy, res_cx, res_peak, res_subap};
    assign m_tuser  = res_spot;

endmodule

`default_nettype wire
